>>> hw/rtl/dpfmod_pkg.sv
// dpfmod_pkg: shared types and constants for the binary64 remainder block.
// No dependencies.
`timescale 1ns / 1ps

package dpfmod_pkg;

   localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
   localparam logic [10:0] EXP_ONES  = 11'h7FF;

   // classified job handed from the front to the back
   typedef struct packed {
      logic        direct;      // result is known, no iteration
      logic [63:0] direct_bits; // that result
      logic        sign;
      logic [52:0] mx;          // raw significands, not yet normalized
      logic [52:0] my;
      logic [11:0] ex;          // exponent, signed view in 12 bits
      logic [11:0] ey;
   } job_type;

endpackage

>>> hw/rtl/double_precision_fmod.sv
// double_precision_fmod: top level of the binary64 remainder block.
// Depends on dpfmod_pkg, dpfmod_front and dpfmod_back.
`timescale 1ns / 1ps

// Binary64 fmod: one remainder word per operand pair, sign of the dividend,
// canonical quiet NaN for invalid cases. Special cases (NaN, |x|<=|y|) go
// straight to the result. Otherwise the back end makes one normalize shift
// per leading zero of a subnormal operand (up to 52 each), one step of the
// shift-subtract loop per unit of exponent difference (up to 2097 once a
// subnormal divisor is normalized), then renormalizes and packs the result.
// A two-word queue lets new operands be taken while the back end works.
module double_precision_fmod import dpfmod_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_dividend_bits,
   input  logic [63:0] req_divisor_bits,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_remainder_bits
);

   job_type job;
   logic    job_valid;
   logic    job_take;

   dpfmod_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_dividend_bits (req_dividend_bits),
      .req_divisor_bits  (req_divisor_bits),
      .job_valid         (job_valid),
      .job               (job),
      .job_take          (job_take)
   );

   dpfmod_back u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (job_valid),
      .job                (job),
      .job_take           (job_take),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_remainder_bits (rsp_remainder_bits)
   );

endmodule

>>> hw/rtl/dpfmod_front.sv
// dpfmod_front: accepts operand words, classifies special cases, and
// pushes jobs into a two-entry queue. Depends on dpfmod_pkg.
`timescale 1ns / 1ps

module dpfmod_front import dpfmod_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_dividend_bits,
   input  logic [63:0] req_divisor_bits,
   output logic        job_valid,
   output job_type     job,
   input  logic        job_take
);

   job_type     q_ff [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        rd_ff, rd_in;
   logic        wr_ff, wr_in;
   job_type     new_job;
   logic [62:0] xa, ya;
   logic        push_ok, take_ok;

   assign xa = req_dividend_bits[62:0];
   assign ya = req_divisor_bits[62:0];

   // classification
   always_comb begin
      new_job      = '0;
      new_job.sign = req_dividend_bits[63];
      new_job.ex   = {1'b0, xa[62:52]};
      new_job.ey   = {1'b0, ya[62:52]};
      new_job.mx   = {(xa[62:52] != 11'd0), xa[51:0]};
      new_job.my   = {(ya[62:52] != 11'd0), ya[51:0]};
      // subnormal exponent is taken as 1 with no hidden bit
      if (xa[62:52] == 11'd0) new_job.ex = 12'd1;
      if (ya[62:52] == 11'd0) new_job.ey = 12'd1;
      if (ya == 63'd0 || ya > {EXP_ONES, 52'd0} || xa[62:52] == EXP_ONES) begin
         new_job.direct      = 1'b1;
         new_job.direct_bits = QNAN_BITS;
      end else if (xa < ya) begin
         new_job.direct      = 1'b1;
         new_job.direct_bits = req_dividend_bits;
      end else if (xa == ya) begin
         new_job.direct      = 1'b1;
         new_job.direct_bits = {req_dividend_bits[63], 63'd0};
      end
   end

   assign req_full  = cnt_ff[1];
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rd_ff];
   assign push_ok   = req_push && !req_full;
   assign take_ok   = job_take && job_valid;

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      wr_in  = wr_ff;
      if (push_ok) wr_in = ~wr_ff;
      if (take_ok) rd_in = ~rd_ff;
      if (push_ok && !take_ok) cnt_in = cnt_ff + 2'd1;
      if (!push_ok && take_ok) cnt_in = cnt_ff - 2'd1;
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) q_ff[wr_ff] <= new_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !take_ok) |=> (cnt_ff == 2'd2))
      else $error("full queue lost an entry");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> (rd_ff == wr_ff))
      else $error("empty queue pointers disagree");

endmodule

>>> hw/rtl/dpfmod_back.sv
// dpfmod_back: normalizes, runs the shift-subtract loop one step a cycle,
// renormalizes and packs the result word. Depends on dpfmod_pkg.
`timescale 1ns / 1ps

module dpfmod_back import dpfmod_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  job_type     job,
   output logic        job_take,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_remainder_bits
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_NRMX = 6'b000010,
      ST_NRMY = 6'b000100,
      ST_LOOP = 6'b001000,
      ST_POST = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type   st_ff, st_in;
   logic [53:0] mx_ff, mx_in;
   logic [52:0] my_ff, my_in;
   logic [11:0] ex_ff, ex_in;
   logic [11:0] ey_ff, ey_in;
   logic        sign_ff, sign_in;
   logic [63:0] res_ff, res_in;
   logic        full_ff, full_in;
   logic [54:0] diff;
   logic [53:0] mrem;
   logic [11:0] sh;
   logic [52:0] den;
   logic [10:0] eout;

   assign rsp_empty          = !full_ff;
   assign rsp_remainder_bits = res_ff;
   assign job_take           = (st_ff == ST_IDLE) && job_valid && !full_ff;

   assign diff = {1'b0, mx_ff} - {2'b00, my_ff};
   assign mrem = diff[54] ? mx_ff : diff[53:0];
   assign sh   = 12'd1 - ex_ff;
   assign den  = (sh > 12'd53) ? 53'd0 : (mx_ff[52:0] >> sh[5:0]);
   assign eout = ex_ff[10:0];

   // sequencer
   always_comb begin
      st_in   = st_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      ex_in   = ex_ff;
      ey_in   = ey_ff;
      sign_in = sign_ff;
      res_in  = res_ff;
      full_in = full_ff;
      if (rsp_pop && full_ff) full_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (job_take) begin
               sign_in = job.sign;
               mx_in   = {1'b0, job.mx};
               my_in   = job.my;
               ex_in   = job.ex;
               ey_in   = job.ey;
               if (job.direct) begin
                  res_in = job.direct_bits;
                  st_in  = ST_DONE;
               end else begin
                  st_in = ST_NRMX;
               end
            end
         end
         ST_NRMX: begin
            if (mx_ff[52]) st_in = ST_NRMY;
            else begin
               mx_in = mx_ff << 1;
               ex_in = ex_ff - 12'd1;
            end
         end
         ST_NRMY: begin
            if (my_ff[52]) st_in = ST_LOOP;
            else begin
               my_in = my_ff << 1;
               ey_in = ey_ff - 12'd1;
            end
         end
         ST_LOOP: begin
            if (!diff[54] && diff[53:0] == 54'd0) begin
               res_in = {sign_ff, 63'd0};
               st_in  = ST_DONE;
            end else if ($signed(ex_ff) > $signed(ey_ff)) begin
               mx_in = {mrem[52:0], 1'b0};
               ex_in = ex_ff - 12'd1;
            end else begin
               mx_in = mrem;
               st_in = ST_POST;
            end
         end
         ST_POST: begin
            if (!mx_ff[52]) begin
               mx_in = mx_ff << 1;
               ex_in = ex_ff - 12'd1;
            end else begin
               if ($signed(ex_ff) > 0)
                  res_in = {sign_ff, eout, mx_ff[51:0]};
               else
                  res_in = {sign_ff, 11'd0, den[51:0]};
               st_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!full_in) begin
               full_in = 1'b1;
               st_in   = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      ex_ff   <= ex_in;
      ey_ff   <= ey_in;
      sign_ff <= sign_in;
      res_ff  <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         full_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         full_ff <= full_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) $onehot(st_ff))
      else $error("state not one-hot");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_LOOP) |-> my_ff[52])
      else $error("divisor significand not normalized in loop");
   assert property (@(posedge clock) disable iff (reset)
      (full_ff && !rsp_pop) |=> (full_ff && $stable(res_ff)))
      else $error("held result changed");

endmodule
